### hw/rtl/mrcp_pkg.sv
package mrcp_pkg;

    localparam int DIGIT_BITS          = 16;
    localparam int RADIX_BITS          = 16;
    localparam int CHUNK_LEN_BITS      = 7;
    localparam int CFG_DATA_BITS       = 16;
    localparam int CFG_INDEX_BITS      = 1;
    localparam int REMAINDER_WORD_BITS = 32;
    localparam int QUOTIENT_BITS       = 16;

    localparam int DEF_REMAINDER_BITS  = 32;
    localparam int DEF_ACC_BITS        = 48;

    localparam logic [RADIX_BITS-1:0]     RADIX_RESET     = 16'd3;
    localparam logic [CHUNK_LEN_BITS-1:0] CHUNK_LEN_RESET = 7'd21;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX        = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHUNK_LENGTH = 1'b1;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;
        logic                  last_digit;
    } mrcp_item_t;

    typedef struct packed {
        logic [RADIX_BITS-1:0]     radix;
        logic [CHUNK_LEN_BITS-1:0] chunk_length;
    } mrcp_cfg_t;

    typedef struct packed {
        logic [REMAINDER_WORD_BITS-1:0] remainder_word;
        logic [QUOTIENT_BITS-1:0]       quotient;
        logic                           all_quotients_zero;
        logic                           final_chunk;
        logic                           overflow;
    } mrcp_result_t;

endpackage

### hw/rtl/mrcp_if.sv
interface mrcp_digit_if;
    import mrcp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DIGIT_BITS-1:0] digit;
    logic                  last_digit;

    modport source (output valid, output digit, output last_digit, input ready);
    modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface mrcp_chunk_if;
    import mrcp_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [REMAINDER_WORD_BITS-1:0] remainder_word;
    logic [QUOTIENT_BITS-1:0]       quotient;
    logic                           all_quotients_zero;
    logic                           final_chunk;
    logic                           overflow;

    modport source (output valid, output remainder_word, output quotient,
                    output all_quotients_zero, output final_chunk, output overflow,
                    input ready);
    modport sink   (input valid, input remainder_word, input quotient,
                    input all_quotients_zero, input final_chunk, input overflow,
                    output ready);
endinterface

### hw/rtl/mrcp_input_stage.sv
module mrcp_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    mrcp_digit_if.sink          digits,
    input  logic                advance,
    output logic                item_valid_reg,
    output mrcp_pkg::mrcp_item_t item_reg
);
    import mrcp_pkg::*;

    logic accept;
    logic item_valid_next;

    assign digits.ready = !item_valid_reg || advance;
    assign accept       = digits.valid && digits.ready;

    always_comb
    begin
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.digit      <= digits.digit;
            item_reg.last_digit <= digits.last_digit;
        end
    end

endmodule

### hw/rtl/mrcp_chunk_unit.sv
module mrcp_chunk_unit #(
    parameter int REMAINDER_BITS = mrcp_pkg::DEF_REMAINDER_BITS,
    parameter int ACC_BITS       = mrcp_pkg::DEF_ACC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrcp_pkg::mrcp_cfg_t   cfg,
    input  logic                  item_valid,
    input  mrcp_pkg::mrcp_item_t  item,
    output logic                  advance,
    input  logic                  result_ready,
    output logic                  result_valid_reg,
    output mrcp_pkg::mrcp_result_t result_reg
);
    import mrcp_pkg::*;

    localparam int PROD_BITS = ACC_BITS + RADIX_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int WIDE_BITS = ACC_BITS + REMAINDER_BITS;
    localparam int REM_EXT   = REMAINDER_BITS + REMAINDER_WORD_BITS;

    logic [ACC_BITS-1:0]       acc_reg;
    logic [CHUNK_LEN_BITS-1:0] count_reg;
    logic                      seen_nz_reg;
    logic                      ovf_seen_reg;
    logic                      result_valid_next;

    logic                      fire;
    logic [PROD_BITS-1:0]      prod;
    logic [SUM_BITS-1:0]       sum;
    logic                      ovf;
    logic [ACC_BITS-1:0]       acc_new;
    logic [CHUNK_LEN_BITS-1:0] count_new;
    logic                      close;
    logic                      ovf_seen_new;
    logic [WIDE_BITS-1:0]      acc_wide;
    logic [ACC_BITS-1:0]       quo_wide;
    logic [REM_EXT-1:0]        rem_ext;
    logic                      quo_nz;
    logic                      nz;
    mrcp_result_t              result_new;

    assign advance = !result_valid_reg || result_ready;
    assign fire    = item_valid && advance;

    // Horner step: the carry out of the ACC_BITS window marks saturation.
    always_comb
    begin
        prod         = PROD_BITS'(acc_reg) * PROD_BITS'(cfg.radix);
        sum          = SUM_BITS'(prod) + SUM_BITS'(item.digit);
        ovf          = |sum[SUM_BITS-1:ACC_BITS];
        acc_new      = ovf ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
        count_new    = count_reg + CHUNK_LEN_BITS'(1);
        close        = item.last_digit || (count_new >= cfg.chunk_length);
        ovf_seen_new = ovf_seen_reg || ovf;

        acc_wide = {{REMAINDER_BITS{1'b0}}, acc_new};
        quo_wide = acc_wide[WIDE_BITS-1:REMAINDER_BITS];
        rem_ext  = {{REMAINDER_WORD_BITS{1'b0}}, acc_wide[REMAINDER_BITS-1:0]};
        quo_nz   = |quo_wide;
        nz       = seen_nz_reg || quo_nz;

        result_new.remainder_word = (rem_ext > REM_EXT'({REMAINDER_WORD_BITS{1'b1}}))
                                    ? {REMAINDER_WORD_BITS{1'b1}}
                                    : rem_ext[REMAINDER_WORD_BITS-1:0];
        result_new.quotient       = (quo_wide > ACC_BITS'({QUOTIENT_BITS{1'b1}}))
                                    ? {QUOTIENT_BITS{1'b1}}
                                    : quo_wide[QUOTIENT_BITS-1:0];
        result_new.all_quotients_zero = item.last_digit && !nz;
        result_new.final_chunk        = item.last_digit;
        result_new.overflow           = ovf_seen_new;
    end

    always_comb
    begin
        if (fire && close)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            count_reg        <= '0;
            seen_nz_reg      <= 1'b0;
            ovf_seen_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (fire)
            begin
                if (close)
                begin
                    acc_reg      <= '0;
                    count_reg    <= '0;
                    ovf_seen_reg <= 1'b0;
                    seen_nz_reg  <= item.last_digit ? 1'b0 : nz;
                end
                else
                begin
                    acc_reg      <= acc_new;
                    count_reg    <= count_new;
                    ovf_seen_reg <= ovf_seen_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && close)
        begin
            result_reg <= result_new;
        end
    end

endmodule

### hw/rtl/mixed_radix_chunk_packer_top.sv
// Mixed-radix chunk packer: digits enter one per cycle, most significant first, and are
// folded into a saturating ACC_BITS accumulator by acc * radix + digit; a chunk closes
// after chunk_length digits or on a digit marked last_digit, and one result word pair
// (low REMAINDER_BITS as remainder_word, the rest as quotient) is presented on chunks
// from result_reg once the closing digit has passed the input stage register and been folded.
// The block sustains one digit per clock; that figure is set by the accumulator feedback
// loop, one ACC_BITS by 16 multiply and add per cycle. A result held by a stalled sink
// stops the pipeline until it is taken. Write radix and chunk_length only while no
// digits are in flight.
module mixed_radix_chunk_packer_top #(
    parameter int REMAINDER_BITS = mrcp_pkg::DEF_REMAINDER_BITS,
    parameter int ACC_BITS       = mrcp_pkg::DEF_ACC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mrcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mrcp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mrcp_digit_if.sink                          digits,
    mrcp_chunk_if.source                        chunks
);
    import mrcp_pkg::*;

    logic [RADIX_BITS-1:0]     radix_reg;
    logic [CHUNK_LEN_BITS-1:0] chunk_length_reg;
    mrcp_cfg_t                 cfg;
    logic                      advance;
    logic                      item_valid;
    mrcp_item_t                item;
    logic                      result_valid;
    mrcp_result_t              result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            chunk_length_reg <= CHUNK_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIX:        radix_reg        <= cfg_data[RADIX_BITS-1:0];
                REG_CHUNK_LENGTH: chunk_length_reg <= cfg_data[CHUNK_LEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.radix        = radix_reg;
    assign cfg.chunk_length = chunk_length_reg;

    mrcp_input_stage u_input_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .digits         (digits),
        .advance        (advance),
        .item_valid_reg (item_valid),
        .item_reg       (item)
    );

    mrcp_chunk_unit #(
        .REMAINDER_BITS (REMAINDER_BITS),
        .ACC_BITS       (ACC_BITS)
    ) u_chunk_unit (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .item_valid       (item_valid),
        .item             (item),
        .advance          (advance),
        .result_ready     (chunks.ready),
        .result_valid_reg (result_valid),
        .result_reg       (result)
    );

    assign chunks.valid              = result_valid;
    assign chunks.remainder_word     = result.remainder_word;
    assign chunks.quotient           = result.quotient;
    assign chunks.all_quotients_zero = result.all_quotients_zero;
    assign chunks.final_chunk        = result.final_chunk;
    assign chunks.overflow           = result.overflow;

endmodule

### tb/mrcp_checker.sv
module mrcp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mrcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mrcp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mrcp_digit_if                               digits,
    mrcp_chunk_if                               chunks,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  chunks_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import mrcp_pkg::*;

    localparam int          ACC_W   = DEF_ACC_BITS;
    localparam int          REM_W   = DEF_REMAINDER_BITS;
    localparam logic [63:0] ACC_MAX = (64'd1 << ACC_W) - 64'd1;
    localparam logic [63:0] REM_MAX = (64'd1 << REM_W) - 64'd1;

    logic [RADIX_BITS-1:0]     radix_q;
    logic [CHUNK_LEN_BITS-1:0] chunk_len_q;
    logic [ACC_W-1:0]          acc_q;
    logic [CHUNK_LEN_BITS-1:0] count_q;
    logic                      quo_nz_q;
    logic                      ovf_q;

    mrcp_result_t chunk_q[$];

    // Folds one digit into the running chunk; returns 1 when the digit closes a chunk.
    function automatic bit fold_digit(input logic [DIGIT_BITS-1:0] d, input logic last,
                                      output mrcp_result_t res);
        logic [63:0] base;
        logic [63:0] next_acc;
        logic [63:0] prod;
        logic [63:0] rem;
        logic [63:0] quo;
        logic        saturate;
        logic        nz;
        base     = 64'(radix_q);
        next_acc = 64'(acc_q);
        saturate = 1'b0;
        res      = '0;
        if (base != 64'd0 && next_acc > ACC_MAX / base)
            saturate = 1'b1;
        else
        begin
            prod = next_acc * base;
            if (prod > ACC_MAX - 64'(d))
                saturate = 1'b1;
            else
                next_acc = prod + 64'(d);
        end
        if (saturate)
        begin
            next_acc = ACC_MAX;
            ovf_q    = 1'b1;
        end
        acc_q   = next_acc[ACC_W-1:0];
        count_q = count_q + CHUNK_LEN_BITS'(1);
        if (!last && count_q < chunk_len_q)
            return 1'b0;

        rem = next_acc & REM_MAX;
        quo = next_acc >> REM_W;
        nz  = quo_nz_q || (quo != 64'd0);
        res.remainder_word     = (rem > 64'hFFFF_FFFF) ? '1 : rem[REMAINDER_WORD_BITS-1:0];
        res.quotient           = (quo > 64'hFFFF) ? '1 : quo[QUOTIENT_BITS-1:0];
        res.all_quotients_zero = last && !nz;
        res.final_chunk        = last;
        res.overflow           = ovf_q;
        quo_nz_q = last ? 1'b0 : nz;
        acc_q    = '0;
        count_q  = '0;
        ovf_q    = 1'b0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mrcp_result_t res;
        mrcp_result_t want;
        if (!rst_n)
        begin
            radix_q     = RADIX_RESET;
            chunk_len_q = CHUNK_LEN_RESET;
            acc_q       = '0;
            count_q     = '0;
            quo_nz_q    = 1'b0;
            ovf_q       = 1'b0;
            chunk_q.delete();
            mismatches  = 0;
            chunks_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIX:        radix_q     = cfg_data[RADIX_BITS-1:0];
                    REG_CHUNK_LENGTH: chunk_len_q = cfg_data[CHUNK_LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (digits.valid && digits.ready)
            begin
                if (fold_digit(digits.digit, digits.last_digit, res))
                    chunk_q.push_back(res);
            end
            if (chunks.valid && chunks.ready)
            begin
                chunks_seen++;
                if (chunk_q.size() == 0)
                begin
                    $error("chunk result with no request waiting: remainder_word 0x%0h",
                           chunks.remainder_word);
                    mismatches++;
                end
                else
                begin
                    want = chunk_q.pop_front();
                    check_field("remainder_word", want.remainder_word, chunks.remainder_word);
                    check_field("quotient", 32'(want.quotient), 32'(chunks.quotient));
                    check_field("all_quotients_zero", 32'(want.all_quotients_zero),
                                32'(chunks.all_quotients_zero));
                    check_field("final_chunk", 32'(want.final_chunk), 32'(chunks.final_chunk));
                    check_field("overflow", 32'(want.overflow), 32'(chunks.overflow));
                end
            end
            outstanding <= chunk_q.size();
        end
    end

endmodule

### tb/mixed_radix_chunk_packer_top_tb.sv
module mixed_radix_chunk_packer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mrcp_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int chunks_seen;
    int digits_sent;
    int settings_used;
    bit no_idle;

    mrcp_digit_if digits ();
    mrcp_chunk_if chunks ();

    mixed_radix_chunk_packer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .digits    (digits),
        .chunks    (chunks)
    );

    mrcp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .digits      (digits),
        .chunks      (chunks),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .chunks_seen (chunks_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_digit(input logic [DIGIT_BITS-1:0] d, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            digits.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        digits.valid      <= 1'b1;
        digits.digit      <= d;
        digits.last_digit <= last;
        @(posedge clk);
        while (!digits.ready) @(posedge clk);
        digits_sent++;
    endtask

    // Waits until every closed chunk has come out, then idles briefly as margin.
    task automatic drain();
        digits.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [RADIX_BITS-1:0] rdx,
                              input logic [CHUNK_LEN_BITS-1:0] len);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RADIX;
        cfg_data  <= CFG_DATA_BITS'(rdx);
        @(posedge clk);
        cfg_index <= REG_CHUNK_LENGTH;
        cfg_data  <= CFG_DATA_BITS'(len);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Result side: a fresh stall is drawn for every result.
    initial
    begin
        int stall;
        chunks.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                chunks.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            chunks.ready <= 1'b1;
            @(posedge clk);
            while (!chunks.valid) @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [RADIX_BITS-1:0]     rdx;
        logic [CHUNK_LEN_BITS-1:0] len;
        logic [DIGIT_BITS-1:0]     d;
        int                        items;
        int                        alen;
        int                        eff_len;
        int                        sel;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        digits.valid      = 1'b0;
        digits.digit      = '0;
        digits.last_digit = 1'b0;
        digits_sent       = 0;
        settings_used     = 0;
        no_idle           = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset; the last digit closes a short partial chunk.
        send_digit(16'd2, 1'b0);
        send_digit(16'd1, 1'b0);
        send_digit(16'd0, 1'b1);
        drain();

        // Four top digits in the widest radix run past the accumulator and saturate,
        // then a zero digit and a digit equal to the radix each form a single-digit final chunk.
        set_config(16'hFFFF, 7'd4);
        repeat (4) send_digit(16'hFFFE, 1'b0);
        send_digit(16'd0, 1'b1);
        send_digit(16'hFFFF, 1'b1);
        drain();

        set_config(16'd2, 7'd1);
        send_digit(16'd1, 1'b0);
        send_digit(16'd0, 1'b1);
        drain();

        // Radix zero and chunk length zero: every digit closes a chunk on its own.
        set_config(16'd0, 7'd0);
        send_digit(16'd5, 1'b0);
        send_digit(16'd7, 1'b1);
        drain();

        set_config(16'd1, 7'd2);
        send_digit(16'd9, 1'b0);
        send_digit(16'hFFFF, 1'b0);
        send_digit(16'd3, 1'b1);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:
                begin
                    rdx = 16'd2;
                    len = 7'd64;
                end
                1:
                begin
                    rdx = 16'hFFFF;
                    len = 7'd1;
                end
                2:
                begin
                    rdx = 16'hFFFF;
                    len = 7'd64;
                end
                3:
                begin
                    rdx = 16'd2;
                    len = 7'd127;
                end
                4:
                begin
                    rdx = 16'd1;
                    len = 7'd0;
                end
                5:
                begin
                    rdx = 16'd0;
                    len = 7'd7;
                end
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        rdx = RADIX_BITS'($urandom_range(2, 16));
                    else
                        rdx = RADIX_BITS'($urandom_range(2, 65535));
                    if ($urandom_range(0, 7) == 0)
                        len = CHUNK_LEN_BITS'($urandom_range(65, 127));
                    else
                        len = CHUNK_LEN_BITS'($urandom_range(1, 64));
                end
            endcase
            no_idle = (phase % 4 == 3);
            set_config(rdx, len);
            eff_len = (len == 0) ? 1 : int'(len);
            items = 0;
            while (items < 75)
            begin
                // Now and then hold off until the block has emptied out.
                if ($urandom_range(0, 39) == 0)
                    drain();
                alen = $urandom_range(1, 2 * eff_len + 2);
                for (int k = 0; k < alen; k++)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0 || rdx == 0)
                        d = DIGIT_BITS'($urandom_range(0, 65535));
                    else if (sel == 1)
                        d = rdx - RADIX_BITS'(1);
                    else
                        d = DIGIT_BITS'($urandom_range(0, int'(rdx) - 1));
                    send_digit(d, k == alen - 1);
                    items++;
                end
            end
            drain();
        end

        no_idle = 1'b0;
        drain();
        $display("Sent %0d digits under %0d register settings,", digits_sent, settings_used);
        $display("radix and chunk length extremes included.");
        $display("Checked %0d chunk results, %0d mismatches.", chunks_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/mrcp_pkg.sv
hw/rtl/mrcp_if.sv
hw/rtl/mrcp_input_stage.sv
hw/rtl/mrcp_chunk_unit.sv
hw/rtl/mixed_radix_chunk_packer_top.sv
tb/mrcp_checker.sv
tb/mixed_radix_chunk_packer_top_tb.sv
